// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the allocator rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ffa_pkg.sv -----
// types and constants of the first-fit heap allocator
// no dependencies; used by ffa_hdr_mem, ffa_ctrl and the top level
package ffa_pkg;

	// fixed geometry
	localparam int ALIGN_BYTES = 8;
	localparam int HDR_W       = 16;
	localparam int MAX_AW      = 12;
	localparam int SZ_W        = 17;
	localparam int WIDE_W      = 15;
	localparam int ADDR_W      = 15;
	localparam int SIZE_W      = 16;

	// operation codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// header memory access, one write and one read port
	typedef struct packed {
		logic              we;
		logic [MAX_AW-1:0] waddr;
		logic [HDR_W-1:0]  wdata;
		logic              re;
		logic [MAX_AW-1:0] raddr;
	} mem_req_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FHDR,
		ST_MERGE,
		ST_MEND,
		ST_SET
	} ffa_state_t;

endpackage

// ----- hw/rtl/ffa_hdr_mem.sv -----
// block header store, one synchronous write port and one registered read port
// depends on ffa_pkg for the access struct
module ffa_hdr_mem #(
	parameter int AW = 12
) (
	input  logic                        clk,
	input  ffa_pkg::mem_req_t           req,
	output logic [ffa_pkg::HDR_W-1:0]   rdata
);

	logic [ffa_pkg::HDR_W-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// read port, write-first so a same-cycle write is seen
	always_ff @(posedge clk) begin
		if (req.re) begin
			if (req.we && (req.waddr[AW-1:0] == req.raddr[AW-1:0])) begin
				rdata <= req.wdata;
			end else begin
				rdata <= mem[req.raddr[AW-1:0]];
			end
		end
	end

endmodule

// ----- hw/rtl/ffa_ctrl.sv -----
// sequencer of the allocator: clearing pass, heap walk, merge, split and free
// depends on ffa_pkg and assert_macros.svh; drives ffa_hdr_mem
`include "assert_macros.svh"
module ffa_ctrl #(
	parameter int HEAP_BYTES = 32768
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [ffa_pkg::SIZE_W-1:0]    req_size,
	input  logic [ffa_pkg::ADDR_W-1:0]    block_addr,
	output logic                          done,
	output logic [ffa_pkg::ADDR_W-1:0]    payload_addr,
	output logic                          success,
	output ffa_pkg::mem_req_t             mem_req,
	input  logic [ffa_pkg::HDR_W-1:0]     mem_rdata
);

	localparam int SLOTS = HEAP_BYTES / ffa_pkg::ALIGN_BYTES;
	localparam int SW    = $clog2(SLOTS);
	localparam logic [ffa_pkg::WIDE_W-1:0] SLOTS_W  = ffa_pkg::WIDE_W'(SLOTS);
	localparam logic [ffa_pkg::SZ_W-1:0]   HEAP_SZ  = ffa_pkg::SZ_W'(HEAP_BYTES);
	localparam logic [SW-1:0]              LAST_IDX = SW'(SLOTS - 1);

	ffa_pkg::ffa_state_t state_q, state_d;

	logic                         cmd_q, cmd_d;
	logic [ffa_pkg::SZ_W-1:0]     need_q, need_d;
	logic [ffa_pkg::SZ_W-1:0]     acc_q, acc_d;
	logic [SW-1:0]                idx_q, idx_d;
	logic [SW-1:0]                nxt_q, nxt_d;
	logic [SW-1:0]                clr_q, clr_d;
	logic                         valid_q;
	logic [ffa_pkg::ADDR_W-1:0]   paddr_q;
	logic                         ok_q;

	logic                         fin;
	logic [ffa_pkg::ADDR_W-1:0]   fin_addr;
	logic                         fin_ok;

	// decoded header and address arithmetic
	logic [ffa_pkg::SZ_W-1:0]     hsz;
	logic                         hused;
	logic [ffa_pkg::WIDE_W-1:0]   hdr_adv, mrg_adv, skip_adv, rest_idx;
	logic [ffa_pkg::SZ_W-1:0]     acc_sum, need_in;
	logic                         fits, split;
	logic [ffa_pkg::ADDR_W-1:0]   foff;
	logic                         faddr_ok, alloc_bad;
	logic [SW-1:0]                fidx;

	assign hsz      = {1'b0, mem_rdata[ffa_pkg::HDR_W-1:1], 1'b0};
	assign hused    = mem_rdata[0];
	assign hdr_adv  = ffa_pkg::WIDE_W'(idx_q) + ffa_pkg::WIDE_W'(hsz >> 3);
	assign mrg_adv  = ffa_pkg::WIDE_W'(nxt_q) + ffa_pkg::WIDE_W'(hsz >> 3);
	assign skip_adv = ffa_pkg::WIDE_W'(idx_q) + ffa_pkg::WIDE_W'(acc_q >> 3);
	assign rest_idx = ffa_pkg::WIDE_W'(idx_q) + ffa_pkg::WIDE_W'(need_q >> 3);
	assign acc_sum  = acc_q + hsz;
	assign fits     = acc_q >= need_q;
	assign split    = (acc_q > need_q) && (rest_idx < SLOTS_W);

	// request decode: rounded block size and free address checks
	assign need_in   = (ffa_pkg::SZ_W'(req_size) + ffa_pkg::SZ_W'(9))
		& ~ffa_pkg::SZ_W'(7);
	assign alloc_bad = (req_size == '0) || (need_in > HEAP_SZ);
	assign foff      = block_addr - ffa_pkg::ADDR_W'(2);
	assign fidx      = foff[SW+2:3];
	assign faddr_ok  = (block_addr >= ffa_pkg::ADDR_W'(2)) && (foff[2:0] == 3'b000)
		&& (ffa_pkg::WIDE_W'(foff >> 3) < SLOTS_W);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffa_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IDX) state_d = ffa_pkg::ST_IDLE;
			end
			ffa_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd == ffa_pkg::CMD_ALLOC) begin
						if (!alloc_bad) state_d = ffa_pkg::ST_WALK;
					end else if (block_addr != '0 && faddr_ok) begin
						state_d = ffa_pkg::ST_FHDR;
					end
				end
			end
			ffa_pkg::ST_WALK: begin
				if (hsz == '0) begin
					state_d = ffa_pkg::ST_IDLE;
				end else if (hused) begin
					if (hdr_adv >= SLOTS_W) state_d = ffa_pkg::ST_IDLE;
				end else if (hdr_adv < SLOTS_W) begin
					state_d = ffa_pkg::ST_MERGE;
				end else begin
					state_d = ffa_pkg::ST_MEND;
				end
			end
			ffa_pkg::ST_FHDR: begin
				if (hsz == '0) begin
					state_d = ffa_pkg::ST_IDLE;
				end else if (hdr_adv < SLOTS_W) begin
					state_d = ffa_pkg::ST_MERGE;
				end else begin
					state_d = ffa_pkg::ST_MEND;
				end
			end
			ffa_pkg::ST_MERGE: begin
				if (hused || hsz == '0 || mrg_adv >= SLOTS_W) state_d = ffa_pkg::ST_MEND;
			end
			ffa_pkg::ST_MEND: begin
				if (cmd_q == ffa_pkg::CMD_FREE) begin
					state_d = ffa_pkg::ST_IDLE;
				end else if (fits) begin
					state_d = ffa_pkg::ST_SET;
				end else if (skip_adv < SLOTS_W) begin
					state_d = ffa_pkg::ST_WALK;
				end else begin
					state_d = ffa_pkg::ST_IDLE;
				end
			end
			ffa_pkg::ST_SET: begin
				state_d = ffa_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffa_pkg::ST_IDLE;
			end
		endcase
	end

	// memory accesses, datapath updates and result
	always_comb begin
		mem_req  = '0;
		fin      = 1'b0;
		fin_addr = '0;
		fin_ok   = 1'b0;
		cmd_d    = cmd_q;
		need_d   = need_q;
		acc_d    = acc_q;
		idx_d    = idx_q;
		nxt_d    = nxt_q;
		clr_d    = clr_q;
		case (state_q)
			ffa_pkg::ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ffa_pkg::MAX_AW'(clr_q);
				mem_req.wdata = (clr_q == '0) ? HEAP_SZ[ffa_pkg::HDR_W-1:0] : '0;
				clr_d         = clr_q + SW'(1);
			end
			ffa_pkg::ST_IDLE: begin
				if (start) begin
					cmd_d = cmd;
					if (cmd == ffa_pkg::CMD_ALLOC) begin
						need_d = need_in;
						if (alloc_bad) begin
							fin = 1'b1;
						end else begin
							idx_d         = '0;
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
						end
					end else if (block_addr == '0) begin
						fin    = 1'b1;
						fin_ok = 1'b1;
					end else if (!faddr_ok) begin
						fin = 1'b1;
					end else begin
						idx_d         = fidx;
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(fidx);
					end
				end
			end
			ffa_pkg::ST_WALK: begin
				if (hsz == '0) begin
					fin = 1'b1;
				end else if (hused) begin
					idx_d = hdr_adv[SW-1:0];
					if (hdr_adv < SLOTS_W) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(hdr_adv[SW-1:0]);
					end else begin
						fin = 1'b1;
					end
				end else begin
					acc_d = hsz;
					nxt_d = hdr_adv[SW-1:0];
					if (hdr_adv < SLOTS_W) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(hdr_adv[SW-1:0]);
					end
				end
			end
			ffa_pkg::ST_FHDR: begin
				// clear the allocated mark
				mem_req.we    = 1'b1;
				mem_req.waddr = ffa_pkg::MAX_AW'(idx_q);
				mem_req.wdata = hsz[ffa_pkg::HDR_W-1:0];
				if (hsz == '0) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end else begin
					acc_d = hsz;
					nxt_d = hdr_adv[SW-1:0];
					if (hdr_adv < SLOTS_W) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(hdr_adv[SW-1:0]);
					end
				end
			end
			ffa_pkg::ST_MERGE: begin
				// absorb a following free block and drop its header
				if (!hused && hsz != '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ffa_pkg::MAX_AW'(nxt_q);
					mem_req.wdata = '0;
					acc_d         = acc_sum;
					nxt_d         = mrg_adv[SW-1:0];
					if (mrg_adv < SLOTS_W) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(mrg_adv[SW-1:0]);
					end
				end
			end
			ffa_pkg::ST_MEND: begin
				if (cmd_q == ffa_pkg::CMD_FREE) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ffa_pkg::MAX_AW'(idx_q);
					mem_req.wdata = acc_q[ffa_pkg::HDR_W-1:0];
					fin           = 1'b1;
					fin_ok        = 1'b1;
				end else if (fits) begin
					// remainder header of the split
					if (split) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = ffa_pkg::MAX_AW'(rest_idx[SW-1:0]);
						mem_req.wdata = ffa_pkg::HDR_W'(acc_q - need_q);
					end
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ffa_pkg::MAX_AW'(idx_q);
					mem_req.wdata = acc_q[ffa_pkg::HDR_W-1:0];
					idx_d         = skip_adv[SW-1:0];
					if (skip_adv < SLOTS_W) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ffa_pkg::MAX_AW'(skip_adv[SW-1:0]);
					end else begin
						fin = 1'b1;
					end
				end
			end
			ffa_pkg::ST_SET: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ffa_pkg::MAX_AW'(idx_q);
				mem_req.wdata = need_q[ffa_pkg::HDR_W-1:0] | ffa_pkg::HDR_W'(1);
				fin           = 1'b1;
				fin_ok        = 1'b1;
				fin_addr      = ffa_pkg::ADDR_W'({idx_q, 3'b010});
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::ST_CLEAR;
			clr_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			valid_q <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		need_q  <= need_d;
		acc_q   <= acc_d;
		idx_q   <= idx_d;
		nxt_q   <= nxt_d;
		paddr_q <= fin_addr;
		ok_q    <= fin_ok;
	end

	assign busy         = (state_q != ffa_pkg::ST_IDLE);
	assign done         = valid_q;
	assign payload_addr = paddr_q;
	assign success      = ok_q;

	`FFA_ASSERT_IMP(a_done_follows_work, clk, arst_n, done, $past(busy) || $past(start), "result without a transaction")
	`FFA_ASSERT_IMP(a_write_in_heap, clk, arst_n, mem_req.we, ffa_pkg::WIDE_W'(mem_req.waddr) < SLOTS_W, "header write beyond heap")
	`FFA_ASSERT_IMP(a_payload_ok, clk, arst_n, done && payload_addr != '0, success && payload_addr[2:0] == 3'b010, "bad payload offset")
	`FFA_ASSERT_IMP(a_clear_busy, clk, arst_n, state_q == ffa_pkg::ST_CLEAR, busy && !done, "activity during clearing pass")
	`FFA_ASSERT_NXT(a_fit_sets, clk, arst_n, state_q == ffa_pkg::ST_MEND && cmd_q == ffa_pkg::CMD_ALLOC && fits, state_q == ffa_pkg::ST_SET, "fitting block not marked")

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// first-fit heap allocator: one header per 8-byte granule in a synchronous memory
// the header walk is paced by the single read port of the header memory; one transaction at a time
// after reset a clearing pass holds busy high, then the heap is one free block
// results appear on done for one cycle, the receiver cannot stall
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES = 32768
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [ffa_pkg::SIZE_W-1:0]  req_size,
	input  logic [ffa_pkg::ADDR_W-1:0]  block_addr,
	output logic                        done,
	output logic [ffa_pkg::ADDR_W-1:0]  payload_addr,
	output logic                        success
);

	localparam int AW = $clog2(HEAP_BYTES / ffa_pkg::ALIGN_BYTES);

	ffa_pkg::mem_req_t           mem_req;
	logic [ffa_pkg::HDR_W-1:0]   mem_rdata;

	// sequencer
	ffa_ctrl #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.req_size    (req_size),
		.block_addr  (block_addr),
		.done        (done),
		.payload_addr(payload_addr),
		.success     (success),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	// header store
	ffa_hdr_mem #(
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench of the first-fit heap allocator: directed and random allocate and free transactions
// depends on ffa_pkg and first_fit_heap_allocator; results are checked against a header-level model
module tb_top;

	localparam int HEAP_BYTES = 32768;
	localparam int SLOTS      = HEAP_BYTES / ffa_pkg::ALIGN_BYTES;
	localparam int HDR_BYTES  = 2;

	typedef struct packed {
		logic [ffa_pkg::ADDR_W-1:0] payload_addr;
		logic                       success;
	} alloc_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       cmd;
	logic [ffa_pkg::SIZE_W-1:0] req_size;
	logic [ffa_pkg::ADDR_W-1:0] block_addr;
	logic                       done;
	logic [ffa_pkg::ADDR_W-1:0] payload_addr;
	logic                       success;

	// model of the header memory, one entry per granule
	logic [ffa_pkg::HDR_W-1:0] heap_hdr [SLOTS];
	alloc_result_t    expected_results [$];
	int unsigned      live_blocks [$];
	int unsigned      error_count = 0;
	bit               gaps_enabled = 1'b1;

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.req_size(req_size),
		.block_addr(block_addr),
		.done(done),
		.payload_addr(payload_addr),
		.success(success)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// absorb the free blocks that follow a block, return the merged size
	function automatic int unsigned absorb_free_followers(int unsigned idx, int unsigned sz);
		int unsigned nxt;
		int unsigned t;
		nxt = idx + sz / ffa_pkg::ALIGN_BYTES;
		while (nxt < SLOTS && heap_hdr[nxt][0] == 1'b0 && heap_hdr[nxt] != '0) begin
			t = heap_hdr[nxt];
			heap_hdr[nxt] = '0;
			sz += t;
			nxt += t / ffa_pkg::ALIGN_BYTES;
		end
		return sz;
	endfunction

	// first-fit walk with merging and split, returns payload offset or 0
	function automatic int unsigned first_fit_alloc(int unsigned size);
		int unsigned need;
		int unsigned idx;
		int unsigned sz;
		logic [ffa_pkg::HDR_W-1:0] hv;
		need = ((size + HDR_BYTES + ffa_pkg::ALIGN_BYTES - 1) / ffa_pkg::ALIGN_BYTES)
			* ffa_pkg::ALIGN_BYTES;
		if (size == 0 || need > HEAP_BYTES)
			return 0;
		idx = 0;
		while (idx < SLOTS) begin
			hv = heap_hdr[idx];
			sz = hv;
			sz[0] = 1'b0;
			if (sz == 0)
				break;
			if (hv[0] == 1'b0) begin
				sz = absorb_free_followers(idx, sz);
				heap_hdr[idx] = sz[ffa_pkg::HDR_W-1:0];
				if (sz >= need) begin
					if (sz > need && idx + need / ffa_pkg::ALIGN_BYTES < SLOTS)
						heap_hdr[idx + need / ffa_pkg::ALIGN_BYTES] = 16'(sz - need);
					heap_hdr[idx] = 16'(need | 1);
					return idx * ffa_pkg::ALIGN_BYTES + HDR_BYTES;
				end
			end
			idx += sz / ffa_pkg::ALIGN_BYTES;
		end
		return 0;
	endfunction

	// clear the allocated mark and merge followers, returns the success flag
	function automatic logic release_block(int unsigned addr);
		int unsigned off;
		int unsigned idx;
		int unsigned sz;
		if (addr == 0)
			return 1'b1;
		if (addr < HDR_BYTES)
			return 1'b0;
		off = addr - HDR_BYTES;
		if (off % ffa_pkg::ALIGN_BYTES != 0)
			return 1'b0;
		idx = off / ffa_pkg::ALIGN_BYTES;
		if (idx >= SLOTS)
			return 1'b0;
		sz = heap_hdr[idx];
		sz[0] = 1'b0;
		heap_hdr[idx] = sz[ffa_pkg::HDR_W-1:0];
		if (sz == 0)
			return 1'b1;
		sz = absorb_free_followers(idx, sz);
		heap_hdr[idx] = sz[ffa_pkg::HDR_W-1:0];
		return 1'b1;
	endfunction

	// send one transaction, predict its result once accepted, then maybe idle
	task automatic issue_request(logic op, int unsigned size, int unsigned addr);
		alloc_result_t want;
		int unsigned p;
		cmd <= op;
		req_size <= size[ffa_pkg::SIZE_W-1:0];
		block_addr <= addr[ffa_pkg::ADDR_W-1:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (op == ffa_pkg::CMD_ALLOC) begin
			p = first_fit_alloc(size);
			want.payload_addr = p[ffa_pkg::ADDR_W-1:0];
			want.success = (p != 0);
			if (p != 0)
				live_blocks.push_back(p);
		end else begin
			want.payload_addr = '0;
			want.success = release_block(addr);
		end
		expected_results.push_back(want);
		// idle burst with junk on the request fields
		if (gaps_enabled && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			cmd <= 1'($urandom);
			req_size <= ffa_pkg::SIZE_W'($urandom);
			block_addr <= ffa_pkg::ADDR_W'($urandom);
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// zero, oversized, exact whole-heap and no-fit requests, then a free of the whole-heap block
	task automatic test_size_extremes();
		issue_request(ffa_pkg::CMD_ALLOC, 0, 32767);
		issue_request(ffa_pkg::CMD_ALLOC, 32768, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 32767, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 32766, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 1, 0);
		issue_request(ffa_pkg::CMD_FREE, 32768, 2);
	endtask

	// double, null, misaligned and interior frees
	task automatic test_free_special_cases();
		issue_request(ffa_pkg::CMD_FREE, 0, 2);
		issue_request(ffa_pkg::CMD_FREE, 0, 0);
		issue_request(ffa_pkg::CMD_FREE, 0, 1);
		issue_request(ffa_pkg::CMD_FREE, 0, 5);
		issue_request(ffa_pkg::CMD_FREE, 0, 32767);
		issue_request(ffa_pkg::CMD_FREE, 0, 32762);
	endtask

	// split small blocks, free them out of order, reuse merged space
	task automatic test_split_and_merge();
		issue_request(ffa_pkg::CMD_ALLOC, 1, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 6, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 7, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 100, 0);
		issue_request(ffa_pkg::CMD_FREE, 0, 18);
		issue_request(ffa_pkg::CMD_FREE, 0, 10);
		issue_request(ffa_pkg::CMD_ALLOC, 20, 0);
		issue_request(ffa_pkg::CMD_FREE, 0, 18);
		issue_request(ffa_pkg::CMD_FREE, 0, 2);
		issue_request(ffa_pkg::CMD_FREE, 0, 34);
		issue_request(ffa_pkg::CMD_ALLOC, 32766, 0);
		issue_request(ffa_pkg::CMD_ALLOC, 16000, 0);
		live_blocks.delete();
	endtask

	// mostly allocate and free of live blocks, some noise frees
	task automatic test_random_traffic(int unsigned count);
		int unsigned pick;
		int unsigned roll;
		int unsigned size;
		int unsigned slot;
		int unsigned addr;
		int unsigned last_freed;
		last_freed = 0;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				roll = $urandom_range(0, 19);
				if (roll < 14)
					size = $urandom_range(1, 64);
				else if (roll < 17)
					size = $urandom_range(65, 2048);
				else if (roll < 18)
					size = $urandom_range(2049, 32768);
				else if (roll < 19)
					size = 0;
				else
					size = $urandom_range(32760, 32768);
				issue_request(ffa_pkg::CMD_ALLOC, size, $urandom_range(0, 32767));
			end else if (pick < 80 && live_blocks.size() != 0) begin
				slot = $urandom_range(0, live_blocks.size() - 1);
				last_freed = live_blocks[slot];
				live_blocks.delete(slot);
				issue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 32768), last_freed);
			end else begin
				roll = $urandom_range(0, 4);
				case (roll)
					0: addr = last_freed;
					1: addr = 0;
					2: addr = $urandom_range(0, SLOTS - 1) * ffa_pkg::ALIGN_BYTES + HDR_BYTES;
					default: addr = $urandom_range(0, 32767);
				endcase
				issue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 32768), addr);
			end
		end
	endtask

	// compare each result with the oldest pending transaction
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: payload_addr %0d success %0d", payload_addr, success);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (payload_addr !== want.payload_addr) begin
					$error("payload_addr: expected %0d, actual %0d",
						want.payload_addr, payload_addr);
					error_count++;
				end
				if (success !== want.success) begin
					$error("success: expected %0d, actual %0d", want.success, success);
					error_count++;
				end
			end
		end
	end

	// sequence of tests
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = ffa_pkg::CMD_ALLOC;
		req_size = '0;
		block_addr = '0;
		foreach (heap_hdr[k])
			heap_hdr[k] = '0;
		heap_hdr[0] = 16'(HEAP_BYTES);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_size_extremes();
		test_free_special_cases();
		test_split_and_merge();
		test_random_traffic(50);
		// back-to-back transactions, no idling
		gaps_enabled = 1'b0;
		test_random_traffic(25);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
